[sv/lps_pkg.sv]
// ============================================================================
// lps_pkg
// Shared types for the line pixel stepper: command word, pixel word and
// operation codes.
// ============================================================================
package lps_pkg;

    localparam int unsigned FIELD_COORD_BITS = 10;
    localparam int unsigned COLOR_BITS       = 8;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef struct packed {
        op_t                          operation;
        logic [FIELD_COORD_BITS-1:0]  x_start;
        logic [FIELD_COORD_BITS-1:0]  y_start;
        logic [FIELD_COORD_BITS-1:0]  x_end;
        logic [FIELD_COORD_BITS-1:0]  y_end;
        logic [COLOR_BITS-1:0]        color;
        logic                         target_buffer;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_COORD_BITS-1:0]  pixel_x;
        logic [FIELD_COORD_BITS-1:0]  pixel_y;
        logic [COLOR_BITS-1:0]        pixel_color;
        logic                         to_buffer;
        logic                         last_pixel;
    } pix_t;

endpackage

[sv/line_pixel_stepper_core.sv]
// ============================================================================
// line_pixel_stepper_core
// Integer line rasterizer: a load word sets up a line, each step word emits
// the next pixel of that line.
// ============================================================================
// usage
//   cmd channel (cmd_valid / cmd_ready / cmd): a load word takes the two
//   endpoints, color and target flag and gives no pixel; a load replaces any
//   line in progress. a step word emits one pixel of the active line, or
//   nothing when no line is active.
//   pix channel (pix_valid / pix_ready / pix): one word per pixel, with
//   last_pixel set on the final one of the line (major length plus one).
// latency and throughput
//   one command word per clock. a pixel shows on pix the cycle after its step
//   word is taken. the step path (error add, compare, subtract and position
//   update) runs between the line state registers and the pixel register.
// stalls
//   cmd_ready drops only while a pixel sits in the output register and
//   pix_ready is low; the block then holds that pixel and all line state.
// reset
//   rst_n clears the line state and the output valid; no line is active.
// coordinates wrap at COORD_BITS, without clipping.
// ============================================================================
module line_pixel_stepper_core
    import lps_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic pix_valid,
    input  logic pix_ready,
    output pix_t pix
);

    localparam int unsigned CB = COORD_BITS;

    // line state
    logic                 active_reg,    active_next;
    logic [CB-1:0]        cur_x_reg,     cur_x_next;
    logic [CB-1:0]        cur_y_reg,     cur_y_next;
    logic [CB-1:0]        error_reg,     error_next;
    logic [CB-1:0]        major_reg,     major_next;
    logic [CB-1:0]        minor_reg,     minor_next;
    logic [CB:0]          left_reg,      left_next;
    logic [1:0]           diag_x_reg,    diag_x_next;
    logic [1:0]           diag_y_reg,    diag_y_next;
    logic [1:0]           str_x_reg,     str_x_next;
    logic [1:0]           str_y_reg,     str_y_next;
    logic [COLOR_BITS-1:0] color_reg,    color_next;
    logic                 target_reg,    target_next;

    logic                 pix_valid_reg, pix_valid_next;
    pix_t                 pix_reg,       pix_next;

    logic cmd_fire;
    logic do_load;
    logic do_step;

    // load setup
    logic [CB+FIELD_COORD_BITS-1:0] x0_wide, y0_wide, x1_wide, y1_wide;
    logic [CB-1:0]  x0, y0, x1, y1;
    logic [CB:0]    dx, dy;
    logic [CB-1:0]  ax, ay;
    logic [1:0]     sx, sy;
    logic           x_major;

    // step path
    logic [CB:0]    err_sum;
    logic           take_diag;
    logic [1:0]     inc_x, inc_y;
    logic [CB+FIELD_COORD_BITS-1:0] out_x_wide, out_y_wide;

    assign cmd_ready = !pix_valid_reg || pix_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign do_load   = cmd_fire && (cmd.operation == OP_LOAD);
    assign do_step   = cmd_fire && (cmd.operation == OP_STEP) && active_reg;

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    always_comb
    begin
        x0_wide = {{CB{1'b0}}, cmd.x_start};
        y0_wide = {{CB{1'b0}}, cmd.y_start};
        x1_wide = {{CB{1'b0}}, cmd.x_end};
        y1_wide = {{CB{1'b0}}, cmd.y_end};
        x0 = x0_wide[CB-1:0];
        y0 = y0_wide[CB-1:0];
        x1 = x1_wide[CB-1:0];
        y1 = y1_wide[CB-1:0];
        dx = {1'b0, x1} - {1'b0, x0};
        dy = {1'b0, y1} - {1'b0, y0};
        ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        sx = dx[CB] ? 2'b11 : ((ax != '0) ? 2'b01 : 2'b00);
        sy = dy[CB] ? 2'b11 : ((ay != '0) ? 2'b01 : 2'b00);
        x_major = ax > ay;
    end

    always_comb
    begin
        // error stays below the major length, so the sum fits in CB+1 bits
        err_sum   = {1'b0, error_reg} + {1'b0, minor_reg};
        take_diag = err_sum >= {1'b0, major_reg};
        inc_x     = take_diag ? diag_x_reg : str_x_reg;
        inc_y     = take_diag ? diag_y_reg : str_y_reg;
        out_x_wide = {{FIELD_COORD_BITS{1'b0}}, cur_x_reg};
        out_y_wide = {{FIELD_COORD_BITS{1'b0}}, cur_y_reg};
    end

    always_comb
    begin
        active_next    = active_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        error_next     = error_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        left_next      = left_reg;
        diag_x_next    = diag_x_reg;
        diag_y_next    = diag_y_reg;
        str_x_next     = str_x_reg;
        str_y_next     = str_y_reg;
        color_next     = color_reg;
        target_next    = target_reg;
        pix_valid_next = pix_valid_reg && !pix_ready;
        pix_next       = pix_reg;

        if (do_load)
        begin
            diag_x_next = sx;
            diag_y_next = sy;
            if (x_major)
            begin
                major_next = ax;
                minor_next = ay;
                str_x_next = sx;
                str_y_next = 2'b00;
            end
            else
            begin
                major_next = ay;
                minor_next = ax;
                str_x_next = 2'b00;
                str_y_next = sy;
            end
            error_next  = major_next >> 1;
            left_next   = {1'b0, major_next} + (CB+1)'(1);
            cur_x_next  = x0;
            cur_y_next  = y0;
            color_next  = cmd.color;
            target_next = cmd.target_buffer;
            active_next = 1'b1;
        end
        else if (do_step)
        begin
            pix_valid_next       = 1'b1;
            pix_next.pixel_x     = out_x_wide[FIELD_COORD_BITS-1:0];
            pix_next.pixel_y     = out_y_wide[FIELD_COORD_BITS-1:0];
            pix_next.pixel_color = color_reg;
            pix_next.to_buffer   = target_reg;
            pix_next.last_pixel  = (left_reg == (CB+1)'(1));

            error_next = take_diag ? CB'(err_sum - {1'b0, major_reg})
                                   : err_sum[CB-1:0];
            cur_x_next = cur_x_reg + {{(CB-2){inc_x[1]}}, inc_x};
            cur_y_next = cur_y_reg + {{(CB-2){inc_y[1]}}, inc_y};
            left_next  = left_reg - (CB+1)'(1);
            if (left_reg == (CB+1)'(1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            error_reg     <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            left_reg      <= '0;
            diag_x_reg    <= '0;
            diag_y_reg    <= '0;
            str_x_reg     <= '0;
            str_y_reg     <= '0;
            color_reg     <= '0;
            target_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            error_reg     <= error_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            left_reg      <= left_next;
            diag_x_reg    <= diag_x_next;
            diag_y_reg    <= diag_y_next;
            str_x_reg     <= str_x_next;
            str_y_reg     <= str_y_next;
            color_reg     <= color_next;
            target_reg    <= target_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // pixel word needs no reset
    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

`ifndef SYNTH
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (left_reg != '0))
        else $error("active line with no pixels left");

    a_error_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((error_reg < major_reg) || (error_reg == '0)))
        else $error("error term out of range");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (do_step && (left_reg == (CB+1)'(1)))
            |=> (!active_reg && pix_valid && pix.last_pixel))
        else $error("final pixel did not end the line");

    a_idle_step_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.operation == OP_STEP) && !active_reg && !pix_valid)
            |=> !pix_valid)
        else $error("pixel emitted without an active line");
`endif

endmodule
